FILE: design/note_arpeggiator_unit_assert.svh
// Assertion macros for the note arpeggiator unit.
// Each macro takes a label, a clock, a reset and two expressions.
`ifndef NOTE_ARPEGGIATOR_UNIT_ASSERT_SVH
`define NOTE_ARPEGGIATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NAU_ASSERT_NOW(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("arpeggiator assertion failed");

// Next-cycle implication.
`define NAU_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("arpeggiator assertion failed");

`endif

FILE: design/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// Shared constants and types of the note arpeggiator unit.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int DIV_W      = 16;   // remainder unit operand width
  localparam int CFG_W      = 28;   // widest configuration register

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN = 3'd0;
  localparam logic [2:0] REG_OCTAVE  = 3'd1;
  localparam logic [2:0] REG_PERIOD  = 3'd2;
  localparam logic [2:0] REG_GATE    = 3'd3;
  localparam logic [2:0] REG_SEED    = 3'd4;

  // input modes
  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // pattern modes
  localparam logic [1:0] PAT_UP      = 2'd0;
  localparam logic [1:0] PAT_DOWN    = 2'd1;
  localparam logic [1:0] PAT_UPDOWN  = 2'd2;
  localparam logic [1:0] PAT_SHUFFLE = 2'd3;

  // event kinds
  localparam logic EV_OFF = 1'b0;
  localparam logic EV_ON  = 1'b1;

  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [15:0] SEED_RESET  = 16'd44257;
  localparam logic [27:0] PERIOD_RST  = 28'd5760000;
  localparam logic [27:0] GATE_RST    = 28'd2880000;
  localparam logic [7:0]  OCT_STEP    = 8'd12;
  localparam logic [7:0]  NOTE_MAX    = 8'd127;
  localparam logic [31:0] TICK_STEP   = 32'd256;

  // handshake between sequencer and remainder unit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: design/nau_ram.sv
// ----------------------------------------------------------------------------
// nau_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nau_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/nau_divider.sv
// ----------------------------------------------------------------------------
// nau_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nau_divider
  import nau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   rem;
  logic [4:0]       cnt;
  logic             run;
  logic             done;
  logic [DIV_W:0]   shifted;

  assign shifted  = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign rsp.done = done;
  assign rsp.rem  = rem[DIV_W-1:0];

  // iterate one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= 5'(DIV_W);
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
      end else if (run) begin
        quo <= {quo[DIV_W-2:0], 1'b0};
        if (shifted >= {1'b0, dvs}) begin
          rem <= shifted - {1'b0, dvs};
        end else begin
          rem <= shifted;
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/note_arpeggiator_unit.sv
// ----------------------------------------------------------------------------
// note_arpeggiator_unit
// Step arpeggiator: held-note set, step sequence rebuild, tick-driven events.
//
//   channel   signals                                  direction
//   item      start, busy (out), mode, key             in
//   config    cfg_we, cfg_index, cfg_data              in
//   result    strobe, event_kind, event_note,          out
//             step_position, last
//
// A rebuild scans 128 notes per octave of span (a second scan for the down
// pattern), then mirrors the inner entries for up-down, or shuffles the
// entries with indexes drawn through the remainder unit; the cursor is
// then wrapped into the new sequence, also through the remainder unit.
// busy stays high until the last beat is out; results cannot be stalled.
// Reset is synchronous; the step memory needs no clearing pass.
// ----------------------------------------------------------------------------
module note_arpeggiator_unit
  import nau_pkg::*;
#(
  parameter int SEQ_DEPTH   = 1024,
  parameter int MAX_OCTAVES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       mode,
  input  logic [6:0]       key,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             strobe,
  output logic             event_kind,
  output logic [6:0]       event_note,
  output logic [9:0]       step_position,
  output logic             last
);

  localparam int AW = $clog2(SEQ_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CNT      = 4'd1;
  localparam logic [3:0] S_FILL     = 4'd2;
  localparam logic [3:0] S_UD_RD    = 4'd3;
  localparam logic [3:0] S_UD_WR    = 4'd4;
  localparam logic [3:0] S_SH_STEP  = 4'd5;
  localparam logic [3:0] S_SH_DIV   = 4'd6;
  localparam logic [3:0] S_SH_RDI   = 4'd7;
  localparam logic [3:0] S_SH_RDJ   = 4'd8;
  localparam logic [3:0] S_SH_WI    = 4'd9;
  localparam logic [3:0] S_SH_WJ    = 4'd10;
  localparam logic [3:0] S_MOD      = 4'd11;
  localparam logic [3:0] S_MOD_WAIT = 4'd12;
  localparam logic [3:0] S_EXEC     = 4'd13;
  localparam logic [3:0] S_ON       = 4'd14;

  // configuration
  logic [1:0]  pattern_mode;
  logic [2:0]  octave_span;
  logic [27:0] step_period;
  logic [27:0] gate_length;

  // block state
  logic [NOTE_COUNT-1:0] held_set;
  logic [CW-1:0]  step_count;
  logic [9:0]     step_cursor;
  logic [31:0]    phase_accum;
  logic           sounding;
  logic [6:0]     sounding_note;
  logic           rebuild_pending;
  logic [15:0]    lfsr_value;

  // sequencer
  logic [3:0]     state;
  logic [1:0]     item_mode;
  logic [6:0]     scan_n;
  logic [3:0]     scan_oct;
  logic [7:0]     scan_off;
  logic [CW-1:0]  fill_b;
  logic [CW-1:0]  total;
  logic [CW-1:0]  walk;       // k for up-down, i for shuffle
  logic [AW-1:0]  swap_j;
  logic [6:0]     swap_t;

  // memory port
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [6:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [6:0]     mem_rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  // scan datapath
  logic [3:0]    span_eff;
  logic [7:0]    scan_v;
  logic          scan_hit;
  logic          scan_end;
  logic [CW-1:0] fill_b_next;
  logic [15:0]   lfsr_next;

  // tick datapath
  logic          off_now;
  logic          step_now;
  logic [15:0]   cur_inc;
  logic [9:0]    cursor_next;
  logic [15:0]   cursor_ext;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (octave_span == 3'd0) begin
      span_eff = 4'd1;
    end else if ({1'b0, octave_span} > 4'(MAX_OCTAVES)) begin
      span_eff = 4'(MAX_OCTAVES);
    end else begin
      span_eff = {1'b0, octave_span};
    end
  end

  assign scan_v      = {1'b0, scan_n} + scan_off;
  assign scan_hit    = held_set[scan_n] && (scan_v <= NOTE_MAX) &&
                       (fill_b < CW'(SEQ_DEPTH));
  assign scan_end    = (scan_n == 7'd127) && (scan_oct == span_eff - 4'd1);
  assign fill_b_next = fill_b + CW'(scan_hit);

  assign lfsr_next = lfsr_value[0] ? ({1'b0, lfsr_value[15:1]} ^ LFSR_TAPS)
                                   : {1'b0, lfsr_value[15:1]};

  assign off_now    = sounding && (phase_accum >= {4'd0, gate_length});
  assign step_now   = (phase_accum >= {4'd0, step_period});
  assign cur_inc    = {6'd0, step_cursor} + 16'd1;
  assign cursor_next = (cur_inc == 16'(step_count)) ? 10'd0 : cur_inc[9:0];
  assign cursor_ext = {6'd0, cursor_next};

  // drive the remainder unit
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = lfsr_next;
    dreq.divisor  = 16'(walk + CW'(1));
    if (state == S_SH_STEP) begin
      dreq.start = 1'b1;
    end else if (state == S_MOD && step_count != '0) begin
      dreq.start    = 1'b1;
      dreq.dividend = {6'd0, step_cursor};
      dreq.divisor  = 16'(step_count);
    end
  end

  // drive the step memory
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_b[AW-1:0];
    mem_wdata = scan_v[6:0];
    mem_raddr = walk[AW-1:0] - AW'(1);
    case (state)
      S_FILL: begin
        mem_we = scan_hit;
        if (pattern_mode == PAT_DOWN) begin
          mem_waddr = AW'(total - CW'(1) - fill_b);
        end
      end
      S_UD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = step_count[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_SH_RDI: mem_raddr = walk[AW-1:0];
      S_SH_RDJ: mem_raddr = swap_j;
      S_SH_WI: begin
        mem_we    = 1'b1;
        mem_waddr = walk[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_SH_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = swap_j;
        mem_wdata = swap_t;
      end
      S_EXEC: mem_raddr = cursor_ext[AW-1:0];
      default: ;
    endcase
  end

  // configuration, sequencer and tick processing
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode    <= PAT_UP;
      octave_span     <= 3'd1;
      step_period     <= PERIOD_RST;
      gate_length     <= GATE_RST;
      lfsr_value      <= SEED_RESET;
      held_set        <= '0;
      step_count      <= '0;
      step_cursor     <= '0;
      phase_accum     <= '0;
      sounding        <= 1'b0;
      sounding_note   <= '0;
      rebuild_pending <= 1'b1;
      state           <= S_IDLE;
      strobe          <= 1'b0;
    end else begin
      strobe <= 1'b0;

      // take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN: begin
            pattern_mode    <= cfg_data[1:0];
            rebuild_pending <= 1'b1;
          end
          REG_OCTAVE: begin
            octave_span     <= cfg_data[2:0];
            rebuild_pending <= 1'b1;
          end
          REG_PERIOD: step_period <= cfg_data;
          REG_GATE:   gate_length <= cfg_data;
          REG_SEED:   lfsr_value  <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            item_mode <= mode;
            scan_n    <= '0;
            scan_oct  <= '0;
            scan_off  <= '0;
            fill_b    <= '0;
            if (mode == MODE_PRESS || mode == MODE_RELEASE) begin
              held_set[key] <= (mode == MODE_PRESS);
              state <= (pattern_mode == PAT_DOWN) ? S_CNT : S_FILL;
            end else if (mode == MODE_TICK) begin
              if (rebuild_pending) begin
                state <= (pattern_mode == PAT_DOWN) ? S_CNT : S_FILL;
              end else begin
                state <= S_EXEC;
              end
            end
          end
        end

        // scan the held notes; for the down pattern, count sequence length, then scan again to write
        S_CNT, S_FILL: begin
          fill_b <= fill_b_next;
          scan_n <= scan_n + 7'd1;
          if (scan_n == 7'd127) begin
            scan_oct <= scan_oct + 4'd1;
            scan_off <= scan_off + OCT_STEP;
          end
          if (scan_end) begin
            scan_oct <= '0;
            scan_off <= '0;
            if (state == S_CNT) begin
              total  <= fill_b_next;
              fill_b <= '0;
              state  <= S_FILL;
            end else begin
              step_count <= fill_b_next;
              walk       <= fill_b_next - CW'(1);
              if (pattern_mode == PAT_UPDOWN && fill_b_next > CW'(2)) begin
                state <= S_UD_RD;
              end else if (pattern_mode == PAT_SHUFFLE && fill_b_next > CW'(1)) begin
                state <= S_SH_STEP;
              end else begin
                state <= S_MOD;
              end
            end
          end
        end

        // mirror the inner notes for up-down
        S_UD_RD: begin
          if (walk > CW'(1) && step_count < CW'(SEQ_DEPTH)) begin
            state <= S_UD_WR;
          end else begin
            state <= S_MOD;
          end
        end
        S_UD_WR: begin
          step_count <= step_count + CW'(1);
          walk       <= walk - CW'(1);
          state      <= S_UD_RD;
        end

        // shuffle: advance LFSR, draw j, swap entries i and j
        S_SH_STEP: begin
          lfsr_value <= lfsr_next;
          state      <= S_SH_DIV;
        end
        S_SH_DIV: begin
          if (drsp.done) begin
            swap_j <= drsp.rem[AW-1:0];
            state  <= S_SH_RDI;
          end
        end
        S_SH_RDI: state <= S_SH_RDJ;
        S_SH_RDJ: begin
          swap_t <= mem_rdata;
          state  <= S_SH_WI;
        end
        S_SH_WI: state <= S_SH_WJ;
        S_SH_WJ: begin
          walk <= walk - CW'(1);
          state <= (walk == CW'(1)) ? S_MOD : S_SH_STEP;
        end

        // wrap the cursor into the new sequence
        S_MOD: begin
          rebuild_pending <= 1'b0;
          state <= (step_count != '0) ? S_MOD_WAIT : S_EXEC;
        end
        S_MOD_WAIT: begin
          if (drsp.done) begin
            step_cursor <= drsp.rem[9:0];
            state       <= S_EXEC;
          end
        end

        // release, advance and emit
        S_EXEC: begin
          state <= S_IDLE;
          if (step_count == '0) begin
            phase_accum <= '0;
            if (sounding) begin
              strobe        <= 1'b1;
              event_kind    <= EV_OFF;
              event_note    <= sounding_note;
              step_position <= step_cursor;
              last          <= 1'b1;
              sounding      <= 1'b0;
            end
          end else if (item_mode == MODE_TICK) begin
            if (off_now || (step_now && sounding)) begin
              strobe        <= 1'b1;
              event_kind    <= EV_OFF;
              event_note    <= sounding_note;
              step_position <= step_cursor;
              last          <= !step_now;
              sounding      <= 1'b0;
            end
            if (step_now) begin
              phase_accum <= phase_accum - {4'd0, step_period} + TICK_STEP;
              step_cursor <= cursor_next;
              state       <= S_ON;
            end else begin
              phase_accum <= phase_accum + TICK_STEP;
            end
          end
        end
        S_ON: begin
          strobe        <= 1'b1;
          event_kind    <= EV_ON;
          event_note    <= mem_rdata;
          step_position <= step_cursor;
          last          <= 1'b1;
          sounding      <= 1'b1;
          sounding_note <= mem_rdata;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  nau_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  nau_ram #(
    .WIDTH (7),
    .DEPTH (SEQ_DEPTH)
  ) u_steps (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: design/nau_checker.sv
// ----------------------------------------------------------------------------
// nau_checker
// Port-level checks of the note arpeggiator unit result stream.
// ----------------------------------------------------------------------------
`include "note_arpeggiator_unit_assert.svh"

module nau_checker
  import nau_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode,
  input logic       strobe,
  input logic       event_kind,
  input logic       last
);

  // a non-final beat is followed at once by the final one
  `NAU_ASSERT_NEXT(a_pair_follows, clk, rst, strobe && !last, strobe && last)

  // the first of two beats releases a note
  `NAU_ASSERT_NOW(a_first_is_off, clk, rst, strobe && !last, event_kind == EV_OFF)

  // an undefined item leaves the block idle
  `NAU_ASSERT_NEXT(a_none_idle, clk, rst, start && !busy && mode == MODE_NONE,
                   !busy && !strobe)

endmodule

bind note_arpeggiator_unit nau_checker u_nau_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .mode       (mode),
  .strobe     (strobe),
  .event_kind (event_kind),
  .last       (last)
);
